// ===== sv/arpc_pkg.sv =====
// Package for the ARP cache table: table size, entry layout, request codes
// and small helpers shared by the cache modules.
// Depends on nothing; every other file of the block but arpc_ram uses it.
package arpc_pkg;

    // Number of cache entries (2 to 256).
    localparam int ENTRIES = 16;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    localparam int IP_W    = 32;
    localparam int MAC_W   = 48;
    localparam int TIME_W  = 32;
    localparam int LIFE_W  = 16;
    localparam int OIDX_W  = 4;

    localparam logic [LIFE_W-1:0] LIFETIME_RST = LIFE_W'(1200);

    // Request codes; the unused code behaves as a lookup.
    localparam logic [1:0] REQ_LOOKUP = 2'd0;
    localparam logic [1:0] REQ_UPDATE = 2'd1;
    localparam logic [1:0] REQ_ADD    = 2'd2;

    typedef logic [IDX_W-1:0] t_idx;

    // One stored entry; the status bit lives in flip-flops outside the RAM.
    typedef struct packed {
        logic [IP_W-1:0]   ip;
        logic [MAC_W-1:0]  mac;
        logic [TIME_W-1:0] stamp;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Result of checking one entry against the current request.
    typedef struct packed {
        logic expired;
        logic match;
    } t_cmp_res;

    // Reported entry index is the slot index modulo 16.
    function automatic logic [OIDX_W-1:0] to_out_idx(input t_idx idx);
        logic [IDX_W+OIDX_W-1:0] ext;
        ext = {{OIDX_W{1'b0}}, idx};
        return ext[OIDX_W-1:0];
    endfunction

endpackage

// ===== sv/arpc_if.sv =====
// Valid/ready channel interfaces for the ARP cache table: the request
// channel and the response channel. Depends on arpc_pkg for field widths.
interface arpc_req_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    req_type;
    logic [arpc_pkg::IP_W-1:0]     ip_addr;
    logic [arpc_pkg::MAC_W-1:0]    mac_addr;
    logic                          entry_status;
    logic [arpc_pkg::TIME_W-1:0]   now_time;

    modport source (output valid, req_type, ip_addr, mac_addr, entry_status, now_time,
                    input ready);
    modport sink   (input valid, req_type, ip_addr, mac_addr, entry_status, now_time,
                    output ready);
endinterface

interface arpc_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          hit;
    logic                          written;
    logic [arpc_pkg::OIDX_W-1:0]   entry_index;
    logic [arpc_pkg::MAC_W-1:0]    mac_out;

    modport source (output valid, hit, written, entry_index, mac_out, input ready);
    modport sink   (input valid, hit, written, entry_index, mac_out, output ready);
endinterface

// ===== sv/arp_cache_table_top.sv =====
// Top level of the ARP cache table with entry aging.
// Depends on arpc_pkg, arpc_if, arpc_ram and arpc_age_cmp.
//
// Usage: a request beat on i_req carries the request type, the IPv4 key, a
// MAC address, a status and the current time. The block scans the table one
// entry per cycle through a single check unit, emptying entries whose age is
// beyond the lifetime, and stops at the first live established match. A
// lookup reports the match; an update also rewrites it; an add rewrites a
// match or else fills the first empty entry. Each request yields exactly one
// response beat on o_rsp.
// Timing: the table sits in a RAM with a registered read, so a scan reads
// one entry ahead of the check, and the response register is loaded from
// the S_FIN state; a scan stops at an early match. Any write to the table
// happens in the same cycle as the last check. i_req.ready is high only
// while the sequencer is idle; one request is in work at a time.
// Stalls: the response sits in an output register, so a new request can be
// accepted and scanned while the previous response waits; a finished scan
// then holds until the output register is free.
// Reset (synchronous, active low) marks every entry empty and sets the
// lifetime to 1200 seconds; no clearing pass is needed. The user must write
// the lifetime via i_cfg_we/i_cfg_wdata only while idle (not enforced).
module arp_cache_table_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    arpc_req_if.sink                    i_req,
    arpc_rsp_if.source                  o_rsp,
    input  logic                        i_cfg_we,
    input  logic [arpc_pkg::LIFE_W-1:0] i_cfg_wdata
);

    // Sequencer states.
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0] r_state;

    // Configuration.
    logic [arpc_pkg::LIFE_W-1:0] r_lifetime;

    // Captured request.
    logic [1:0]                  r_req_type;
    logic [arpc_pkg::IP_W-1:0]   r_ip;
    logic [arpc_pkg::MAC_W-1:0]  r_mac;
    logic                        r_status;
    logic [arpc_pkg::TIME_W-1:0] r_now;

    // Scan bookkeeping: read counter runs one entry ahead of the check.
    logic [arpc_pkg::CNT_W-1:0]  r_rd_cnt;
    logic                        r_chk_vld;
    arpc_pkg::t_idx              r_chk_idx;
    logic                        r_free_vld;
    arpc_pkg::t_idx              r_free_idx;

    // Per-entry status bits; cleared by reset, so the RAM needs no clearing.
    logic [arpc_pkg::ENTRIES-1:0] r_valid;
    logic [arpc_pkg::ENTRIES-1:0] n_valid;

    // Result being built.
    logic                        r_res_hit;
    logic                        r_res_wr;
    arpc_pkg::t_idx              r_res_idx;
    logic [arpc_pkg::MAC_W-1:0]  r_res_mac;

    // Output register.
    logic                          r_rsp_vld;
    logic                          n_rsp_vld;
    logic                          r_out_hit;
    logic                          r_out_wr;
    logic [arpc_pkg::OIDX_W-1:0]   r_out_idx;
    logic [arpc_pkg::MAC_W-1:0]    r_out_mac;

    logic [arpc_pkg::ENTRY_W-1:0] ram_rdata;
    arpc_pkg::t_entry             entry;
    arpc_pkg::t_entry             wr_entry;
    arpc_pkg::t_idx               ram_raddr;
    arpc_pkg::t_idx               ram_waddr;
    logic                         ram_we;
    arpc_pkg::t_cmp_res           cmp;

    logic           scan_live;
    logic           is_last;
    logic           slot_free;
    logic           free_now;
    arpc_pkg::t_idx free_idx;
    logic           is_wr_req;
    logic           hit_now;
    logic           miss_end;
    logic           add_fill;
    logic           new_status;

    // The read address stays inside the table even when the counter has run
    // past the last entry.
    assign ram_raddr = (r_rd_cnt < arpc_pkg::CNT_W'(arpc_pkg::ENTRIES))
                       ? r_rd_cnt[arpc_pkg::IDX_W-1:0] : '0;

    assign entry = arpc_pkg::t_entry'(ram_rdata);

    arpc_ram #(
        .WIDTH (arpc_pkg::ENTRY_W),
        .DEPTH (arpc_pkg::ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (wr_entry),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    arpc_age_cmp u_cmp (
        .i_now_time    (r_now),
        .i_lifetime    (r_lifetime),
        .i_key_ip      (r_ip),
        .i_entry       (entry),
        .i_entry_valid (r_valid[r_chk_idx]),
        .o_res         (cmp)
    );

    always_comb begin
        scan_live  = (r_state == S_SCAN) && r_chk_vld;
        is_last    = r_chk_idx == arpc_pkg::IDX_W'(arpc_pkg::ENTRIES - 1);
        slot_free  = !r_valid[r_chk_idx] || cmp.expired;
        free_now   = r_free_vld || slot_free;
        free_idx   = r_free_vld ? r_free_idx : r_chk_idx;
        is_wr_req  = (r_req_type == arpc_pkg::REQ_UPDATE) ||
                     (r_req_type == arpc_pkg::REQ_ADD);
        hit_now    = scan_live && cmp.match;
        miss_end   = scan_live && !cmp.match && is_last;
        add_fill   = miss_end && (r_req_type == arpc_pkg::REQ_ADD) && free_now;
        ram_we     = (hit_now && is_wr_req) || add_fill;
        ram_waddr  = hit_now ? r_chk_idx : free_idx;
        new_status = (r_req_type == arpc_pkg::REQ_ADD) ? r_status : 1'b1;
        wr_entry.ip    = r_ip;
        wr_entry.mac   = r_mac;
        wr_entry.stamp = r_now;
        // A write follows the aging clear, so it takes effect.
        n_valid = r_valid;
        if (scan_live && cmp.expired) begin
            n_valid[r_chk_idx] = 1'b0;
        end
        if (ram_we) begin
            n_valid[ram_waddr] = new_status;
        end
        n_rsp_vld = r_rsp_vld;
        if (r_rsp_vld && o_rsp.ready) begin
            n_rsp_vld = 1'b0;
        end
        if ((r_state == S_FIN) && (!r_rsp_vld || o_rsp.ready)) begin
            n_rsp_vld = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_lifetime <= arpc_pkg::LIFETIME_RST;
            r_valid    <= '0;
            r_rsp_vld  <= 1'b0;
            r_rd_cnt   <= '0;
            r_chk_vld  <= 1'b0;
            r_free_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_lifetime <= i_cfg_wdata;
            end
            r_rsp_vld <= n_rsp_vld;
            r_valid   <= n_valid;
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_req_type <= i_req.req_type;
                        r_ip       <= i_req.ip_addr;
                        r_mac      <= i_req.mac_addr;
                        r_status   <= i_req.entry_status;
                        r_now      <= i_req.now_time;
                        r_rd_cnt   <= '0;
                        r_chk_vld  <= 1'b0;
                        r_free_vld <= 1'b0;
                        r_res_hit  <= 1'b0;
                        r_res_wr   <= 1'b0;
                        r_res_idx  <= '0;
                        r_res_mac  <= '0;
                        r_state    <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_rd_cnt < arpc_pkg::CNT_W'(arpc_pkg::ENTRIES)) begin
                        r_rd_cnt <= r_rd_cnt + 1'b1;
                    end
                    r_chk_vld <= 1'b1;
                    r_chk_idx <= r_rd_cnt[arpc_pkg::IDX_W-1:0];
                    if (scan_live) begin
                        if (!r_free_vld && slot_free) begin
                            r_free_vld <= 1'b1;
                            r_free_idx <= r_chk_idx;
                        end
                    end
                    if (hit_now) begin
                        r_res_hit <= 1'b1;
                        r_res_wr  <= is_wr_req;
                        r_res_idx <= r_chk_idx;
                        r_res_mac <= is_wr_req ? r_mac : entry.mac;
                    end
                    if (add_fill) begin
                        r_res_wr  <= 1'b1;
                        r_res_idx <= free_idx;
                        r_res_mac <= r_mac;
                    end
                    if (hit_now || miss_end) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (!r_rsp_vld || o_rsp.ready) begin
                        r_out_hit <= r_res_hit;
                        r_out_wr  <= r_res_wr;
                        r_out_idx <= arpc_pkg::to_out_idx(r_res_idx);
                        r_out_mac <= r_res_mac;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_req.ready       = (r_state == S_IDLE);
    assign o_rsp.valid       = r_rsp_vld;
    assign o_rsp.hit         = r_out_hit;
    assign o_rsp.written     = r_out_wr;
    assign o_rsp.entry_index = r_out_idx;
    assign o_rsp.mac_out     = r_out_mac;

`ifndef SYNTHESIS
    // A table write always closes the scan.
    a_write_ends_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |=> (r_state == S_FIN))
        else $error("table write did not end the scan");

    // The entry under check was read before the read counter moved past it.
    a_check_behind_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SCAN) && r_chk_vld) |->
            (arpc_pkg::CNT_W'(r_chk_idx) < r_rd_cnt))
        else $error("checked entry is ahead of the read counter");

    // A response with neither hit nor write reports index and MAC as zero.
    a_empty_response: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.hit && !o_rsp.written) |->
            ((o_rsp.entry_index == '0) && (o_rsp.mac_out == '0)))
        else $error("response without hit or write carries data");

    // With a free output register the finished scan is delivered at once.
    a_finish_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_FIN) && !r_rsp_vld) |=> (r_rsp_vld && (r_state == S_IDLE)))
        else $error("finished scan was not moved to the output register");
`endif

endmodule

// ===== sv/arpc_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. Stands alone; no package needed.
module arpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/arpc_age_cmp.sv =====
// Entry check unit of the ARP cache: ages one entry against the request time
// and compares its address with the key. Depends on arpc_pkg.
module arpc_age_cmp (
    input  logic [arpc_pkg::TIME_W-1:0] i_now_time,
    input  logic [arpc_pkg::LIFE_W-1:0] i_lifetime,
    input  logic [arpc_pkg::IP_W-1:0]   i_key_ip,
    input  arpc_pkg::t_entry            i_entry,
    input  logic                        i_entry_valid,
    output arpc_pkg::t_cmp_res          o_res
);

    logic [arpc_pkg::TIME_W-1:0] elapsed;

    // Elapsed time wraps with the clock, so an unsigned difference is right.
    assign elapsed = i_now_time - i_entry.stamp;

    always_comb begin
        o_res.expired = elapsed > arpc_pkg::TIME_W'(i_lifetime);
        o_res.match   = !o_res.expired && i_entry_valid && (i_entry.ip == i_key_ip);
    end

endmodule
